[rtl/core/slpq_pkg.sv]
// Shared constants, codes and control types of the sorted-list priority queue.
package slpq_pkg;

	localparam int DEPTH   = 256;
	localparam int SLOT_W  = $clog2(DEPTH);
	localparam int PTR_W   = SLOT_W + 1;
	localparam int KEY_W   = 32;
	localparam int PAY_W   = 16;
	localparam int KP_W    = KEY_W + PAY_W;
	localparam int CNT_W   = 9;
	localparam int STAT_W  = 2;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] CASE_EMPTY  = 2'd0;
	localparam logic [1:0] CASE_FRONT  = 2'd1;
	localparam logic [1:0] CASE_TAIL   = 2'd2;
	localparam logic [1:0] CASE_MIDDLE = 2'd3;

	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_IDLE       = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LATCH      = 4'd1;
	localparam logic [CMD_W-1:0] CMD_DECIDE     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_CLASSIFY   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_WALK_FIRST = 4'd4;
	localparam logic [CMD_W-1:0] CMD_WALK       = 4'd5;
	localparam logic [CMD_W-1:0] CMD_LINK1      = 4'd6;
	localparam logic [CMD_W-1:0] CMD_LINK2      = 4'd7;
	localparam logic [CMD_W-1:0] CMD_REM_TAKE   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_REM_HEAD   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd10;

	typedef struct packed {
		logic [CMD_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic       is_remove;
		logic       list_empty;
		logic       list_full;
		logic [1:0] ins_case;
		logic       walk_stop;
		logic       next_nil;
		logic       out_free;
	} stat_t;

endpackage

[rtl/core/sorted_list_priority_queue.sv]
// Top level of the sorted-list priority queue: controller plus datapath.
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  operation, new_key, new_payload
// out      source     out_valid / out_stall status, removed_key, removed_payload, occupied
// cfg      sink       cfg_valid / cfg_ready cfg_data (capacity)
//
// One transaction at a time, stalled from its accept edge until the controller is idle.
// A dropped insert or a remove on an empty list only decides; a remove takes the head and
// reads the new head key when entries remain; a tail or middle insert also relinks its
// predecessor; a middle insert walks the list first, paced by the next-pointer RAM read.
// Reset leaves the list empty and the free chain in slot order, no clearing pass.
// A finished result waits in the output register while the next transaction is taken;
// a transaction ends only once its result can enter that register.
module sorted_list_priority_queue import slpq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [KEY_W-1:0]  new_key,
	input  logic [PAY_W-1:0]  new_payload,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [KEY_W-1:0]  removed_key,
	output logic [PAY_W-1:0]  removed_payload,
	output logic [CNT_W-1:0]  occupied,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	slpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	slpq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.new_key         (new_key),
		.new_payload     (new_payload),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.removed_key     (removed_key),
		.removed_payload (removed_payload),
		.occupied        (occupied)
	);

endmodule

[rtl/core/slpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/core/slpq_ctrl.sv]
// Controller state machine sequencing inserts, list walks and removes.
module slpq_ctrl import slpq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE       = 4'd0;
	localparam logic [ST_W-1:0] S_DECIDE     = 4'd1;
	localparam logic [ST_W-1:0] S_CLASSIFY   = 4'd2;
	localparam logic [ST_W-1:0] S_WALK_FIRST = 4'd3;
	localparam logic [ST_W-1:0] S_WALK       = 4'd4;
	localparam logic [ST_W-1:0] S_LINK1      = 4'd5;
	localparam logic [ST_W-1:0] S_LINK2      = 4'd6;
	localparam logic [ST_W-1:0] S_REM_TAKE   = 4'd7;
	localparam logic [ST_W-1:0] S_REM_HEAD   = 4'd8;
	localparam logic [ST_W-1:0] S_DONE       = 4'd9;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.step = CMD_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.step = CMD_LATCH;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.step = CMD_DECIDE;
				if (stat.is_remove) begin
					state_d = stat.list_empty ? S_DONE : S_REM_TAKE;
				end else begin
					state_d = stat.list_full ? S_DONE : S_CLASSIFY;
				end
			end
			S_CLASSIFY: begin
				cmd.step = CMD_CLASSIFY;
				state_d  = (stat.ins_case == CASE_MIDDLE) ? S_WALK_FIRST : S_LINK1;
			end
			S_WALK_FIRST: begin
				cmd.step = CMD_WALK_FIRST;
				state_d  = S_WALK;
			end
			S_WALK: begin
				cmd.step = CMD_WALK;
				if (stat.walk_stop) begin
					state_d = S_LINK1;
				end
			end
			S_LINK1: begin
				cmd.step = CMD_LINK1;
				if (stat.ins_case == CASE_TAIL || stat.ins_case == CASE_MIDDLE) begin
					state_d = S_LINK2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LINK2: begin
				cmd.step = CMD_LINK2;
				state_d  = S_DONE;
			end
			S_REM_TAKE: begin
				cmd.step = CMD_REM_TAKE;
				state_d  = stat.next_nil ? S_DONE : S_REM_HEAD;
			end
			S_REM_HEAD: begin
				cmd.step = CMD_REM_HEAD;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.step = CMD_LOAD;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/slpq_dp.sv]
// Datapath: slot stores, list pointers, walk cursor, capacity and result register.
module slpq_dp import slpq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              operation,
	input  logic [KEY_W-1:0]  new_key,
	input  logic [PAY_W-1:0]  new_payload,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [KEY_W-1:0]  removed_key,
	output logic [PAY_W-1:0]  removed_payload,
	output logic [CNT_W-1:0]  occupied
);

	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  eff_cap;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [PTR_W-1:0]  free_q;
	logic [PTR_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  count_q;
	logic [KEY_W-1:0]  head_key_q;
	logic [KEY_W-1:0]  tail_key_q;
	logic [SLOT_W-1:0] s_q;
	logic [PTR_W-1:0]  nf_q;
	logic [PTR_W-1:0]  cur_q;
	logic [PTR_W-1:0]  nx_q;
	logic [1:0]        case_q;
	logic [1:0]        ins_case;
	logic [STAT_W-1:0] res_status_q;
	logic [KEY_W-1:0]  res_key_q;
	logic [PAY_W-1:0]  res_pay_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [CNT_W-1:0]  out_count_q;

	logic              nxt_we;
	logic [SLOT_W-1:0] nxt_waddr;
	logic [PTR_W-1:0]  nxt_wdata;
	logic [SLOT_W-1:0] nxt_raddr;
	logic [PTR_W-1:0]  nxt_rdata;
	logic              kp_we;
	logic [SLOT_W-1:0] kp_raddr;
	logic [KP_W-1:0]   kp_rdata;
	logic [KEY_W-1:0]  rd_key;
	logic [PAY_W-1:0]  rd_pay;

	assign rd_key = kp_rdata[KP_W-1:PAY_W];
	assign rd_pay = kp_rdata[PAY_W-1:0];

	always_comb begin
		eff_cap = capacity_q;
		if (capacity_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (capacity_q > CNT_W'(DEPTH)) begin
			eff_cap = CNT_W'(DEPTH);
		end
	end

	always_comb begin
		if (count_q == '0) begin
			ins_case = CASE_EMPTY;
		end else if (key_q <= head_key_q) begin
			ins_case = CASE_FRONT;
		end else if (key_q >= tail_key_q) begin
			ins_case = CASE_TAIL;
		end else begin
			ins_case = CASE_MIDDLE;
		end
	end

	always_comb begin
		stat.is_remove  = (op_q == OP_REMOVE);
		stat.list_empty = (count_q == '0);
		stat.list_full  = (count_q >= eff_cap) || (free_q == NIL);
		stat.ins_case   = (cmd.step == CMD_CLASSIFY) ? ins_case : case_q;
		stat.walk_stop  = (nx_q == NIL) || (rd_key > key_q);
		stat.next_nil   = (nxt_rdata == NIL);
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// RAM port steering
	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = s_q;
		nxt_wdata = nx_q;
		nxt_raddr = head_q[SLOT_W-1:0];
		kp_we     = 1'b0;
		kp_raddr  = head_q[SLOT_W-1:0];
		case (cmd.step)
			CMD_DECIDE: begin
				if (op_q == OP_INSERT) begin
					nxt_raddr = free_q[SLOT_W-1:0];
				end
			end
			CMD_WALK_FIRST, CMD_WALK: begin
				nxt_raddr = nxt_rdata[SLOT_W-1:0];
				kp_raddr  = nxt_rdata[SLOT_W-1:0];
			end
			CMD_LINK1: begin
				nxt_we = 1'b1;
				kp_we  = 1'b1;
			end
			CMD_LINK2: begin
				nxt_we    = 1'b1;
				nxt_waddr = cur_q[SLOT_W-1:0];
				nxt_wdata = {1'b0, s_q};
			end
			CMD_REM_TAKE: begin
				nxt_we    = 1'b1;
				nxt_waddr = head_q[SLOT_W-1:0];
				nxt_wdata = free_q;
				kp_raddr  = nxt_rdata[SLOT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	slpq_ram #(
		.WIDTH(PTR_W),
		.DEPTH(DEPTH)
	) u_next_ram (
		.clk     (clk),
		.wr_en   (nxt_we),
		.wr_addr (nxt_waddr),
		.wr_data (nxt_wdata),
		.rd_addr (nxt_raddr),
		.rd_data (nxt_rdata)
	);

	slpq_ram #(
		.WIDTH(KP_W),
		.DEPTH(DEPTH)
	) u_kp_ram (
		.clk     (clk),
		.wr_en   (kp_we),
		.wr_addr (s_q),
		.wr_data ({key_q, pay_q}),
		.rd_addr (kp_raddr),
		.rd_data (kp_rdata)
	);

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CNT_W'(DEPTH);
			head_q     <= NIL;
			tail_q     <= NIL;
			free_q     <= '0;
			fresh_q    <= '0;
			count_q    <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			case (cmd.step)
				CMD_LINK1: begin
					count_q <= count_q + CNT_W'(1);
					free_q  <= nf_q;
					if ({1'b0, s_q} == fresh_q) begin
						fresh_q <= fresh_q + PTR_W'(1);
					end
					if (case_q == CASE_EMPTY || case_q == CASE_FRONT) begin
						head_q <= {1'b0, s_q};
					end
					if (case_q == CASE_EMPTY || nx_q == NIL) begin
						tail_q <= {1'b0, s_q};
					end
				end
				CMD_REM_TAKE: begin
					count_q <= count_q - CNT_W'(1);
					free_q  <= head_q;
					head_q  <= nxt_rdata;
					if (nxt_rdata == NIL) begin
						tail_q <= NIL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// operation payload, cursor and result
	always_ff @(posedge clk) begin
		case (cmd.step)
			CMD_LATCH: begin
				op_q  <= operation;
				key_q <= new_key;
				pay_q <= new_payload;
			end
			CMD_DECIDE: begin
				res_key_q <= '0;
				res_pay_q <= '0;
				if (op_q == OP_REMOVE) begin
					res_status_q <= (count_q == '0) ? ST_EMPTY : ST_DONE;
				end else begin
					res_status_q <= stat.list_full ? ST_FULL : ST_DONE;
				end
			end
			CMD_CLASSIFY: begin
				s_q    <= free_q[SLOT_W-1:0];
				case_q <= ins_case;
				nf_q   <= (free_q >= fresh_q) ? free_q + PTR_W'(1) : nxt_rdata;
				cur_q  <= tail_q;
				nx_q   <= (ins_case == CASE_FRONT) ? head_q : NIL;
			end
			CMD_WALK_FIRST: begin
				cur_q <= head_q;
				nx_q  <= nxt_rdata;
			end
			CMD_WALK: begin
				if (!stat.walk_stop) begin
					cur_q <= nx_q;
					nx_q  <= nxt_rdata;
				end
			end
			CMD_LINK1: begin
				if (case_q == CASE_EMPTY || case_q == CASE_FRONT) begin
					head_key_q <= key_q;
				end
				if (case_q == CASE_EMPTY || nx_q == NIL) begin
					tail_key_q <= key_q;
				end
			end
			CMD_REM_TAKE: begin
				res_key_q <= rd_key;
				res_pay_q <= rd_pay;
			end
			CMD_REM_HEAD: begin
				head_key_q <= rd_key;
			end
			CMD_LOAD: begin
				out_status_q <= res_status_q;
				out_key_q    <= res_key_q;
				out_pay_q    <= res_pay_q;
				out_count_q  <= count_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step == CMD_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign removed_key     = out_key_q;
	assign removed_payload = out_pay_q;
	assign occupied        = out_count_q;

endmodule
